/* src/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge min-heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam int MAX_LISTS = 16;
  localparam int KEY_BITS  = 32;
  localparam int SRC_W     = 4;
  localparam int PORT_KEY_W = 32;
  localparam int PORT_CNT_W = 5;

  localparam int IDX_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int CNT_W = $clog2(MAX_LISTS + 1);
  // Child indexes reach 2*MAX_LISTS, one bit more than a count.
  localparam int CHW   = IDX_W + 2;

  typedef logic signed [KEY_BITS-1:0]   key_t;
  typedef logic signed [PORT_KEY_W-1:0] port_key_t;
  typedef logic [SRC_W-1:0]             src_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [CHW-1:0]               child_t;

  typedef struct packed {
    key_t key;
    src_t src;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_BUILD   = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PICK_PARENT = 3'b001,
    PICK_LEFT   = 3'b010,
    PICK_RIGHT  = 3'b100
  } pick_t;

  typedef struct packed {
    logic l_ok;
    logic r_ok;
  } child_ok_t;

endpackage

`default_nettype wire

/* src/k_way_merge_min_heap_unit.sv */
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_unit
// Binary min-heap of list heads for a k-way merge, held in a dual-read RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_action, in_key, in_source) load an entry, build the
//   heap, replace the top key or remove the top entry. Every input transaction
//   yields exactly one output transaction with the root entry, the entry count,
//   an empty flag and a reject flag.
//   A load goes from acceptance straight to the final state. Replace and remove
//   sift a hole down through L heap levels (at most 5 for 16 entries); remove
//   first reads the last entry in a load state. Each level is one child read
//   step and one compare/write step on the RAM. Build reads every entry from
//   (count-1)/2 down to the root in turn and sifts it down the same way.
//   One item is in work at a time; in_ready is high only while idle.
//   The result sits in an output register, so the next input transaction can
//   be accepted while it waits. When the receiver stalls, a finished item
//   waits in its final state until the output register frees up.
//   Reset empties the heap and clears the ordered flag; the RAM contents are
//   not cleared, only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_merge_min_heap_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic signed [31:0]  in_key,
  input  logic [3:0]          in_source,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_top_key,
  output logic [3:0]          out_top_source,
  output logic [4:0]          out_entry_count,
  output logic                out_is_empty,
  output logic                out_rejected
);
  import kwm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOADV = 5'b00010,
    ST_READC = 5'b00100,
    ST_CMP   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  cnt_t      cnt_r, cnt_nxt;
  logic      ordered_r, ordered_nxt;
  logic      build_r, build_nxt;
  logic      rej_r, rej_nxt;
  idx_t      pos_r, pos_nxt;
  idx_t      bpos_r, bpos_nxt;
  entry_t    v_r, v_nxt;
  entry_t    top_r, top_nxt;

  logic      out_valid_r, out_valid_nxt;
  port_key_t out_key_r, out_key_nxt;
  src_t      out_src_r, out_src_nxt;
  cnt_t      out_cnt_r, out_cnt_nxt;
  logic      out_empty_r, out_empty_nxt;
  logic      out_rej_r, out_rej_nxt;

  logic      ram_we;
  idx_t      ram_waddr, ram_ra, ram_rb;
  entry_t    ram_wdata, ram_rdata_a, ram_rdata_b;

  child_t    l_idx, r_idx;
  child_ok_t ok;
  pick_t     pick;
  cnt_t      cnt_m1;
  entry_t    in_entry;
  action_t   act;

  assign l_idx    = {1'b0, pos_r, 1'b1};
  assign r_idx    = l_idx + CHW'(1);
  assign ok.l_ok  = l_idx < CHW'(cnt_r);
  assign ok.r_ok  = r_idx < CHW'(cnt_r);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign in_entry = '{key: key_t'(in_key), src: in_source};
  assign act      = action_t'(in_action);

  kwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LISTS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_rb),
    .rdata_b (ram_rdata_b)
  );

  kwm_sift u_sift (
    .v_key (v_r.key),
    .l_key (ram_rdata_a.key),
    .r_key (ram_rdata_b.key),
    .ok    (ok),
    .pick  (pick)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ordered_nxt   = ordered_r;
    build_nxt     = build_r;
    rej_nxt       = rej_r;
    pos_nxt       = pos_r;
    bpos_nxt      = bpos_r;
    v_nxt         = v_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_src_nxt   = out_src_r;
    out_cnt_nxt   = out_cnt_r;
    out_empty_nxt = out_empty_r;
    out_rej_nxt   = out_rej_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = v_r;
    ram_ra        = l_idx[IDX_W-1:0];
    ram_rb        = r_idx[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rej_nxt   = 1'b0;
          build_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_FIN;
          case (act)
            ACT_LOAD: begin
              if ((cnt_r == CNT_W'(MAX_LISTS)) || ordered_r) begin
                rej_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[IDX_W-1:0];
                ram_wdata = in_entry;
                if (cnt_r == '0) begin
                  top_nxt = in_entry;
                end
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            ACT_BUILD: begin
              ordered_nxt = 1'b1;
              if (cnt_r != '0) begin
                // Sift each node from (count-1)/2 down to the root, the highest index first.
                bpos_nxt  = IDX_W'(cnt_m1 >> 1);
                pos_nxt   = IDX_W'(cnt_m1 >> 1);
                ram_ra    = IDX_W'(cnt_m1 >> 1);
                build_nxt = 1'b1;
                state_nxt = ST_LOADV;
              end
            end
            ACT_REPLACE: begin
              if (cnt_r == '0) begin
                rej_nxt = 1'b1;
              end else begin
                v_nxt     = '{key: in_entry.key, src: top_r.src};
                state_nxt = ST_READC;
              end
            end
            ACT_REMOVE: begin
              if (cnt_r == '0) begin
                rej_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_m1;
                ram_ra  = cnt_m1[IDX_W-1:0];
                if (cnt_r == CNT_W'(1)) begin
                  ordered_nxt = 1'b0;
                end
                state_nxt = ST_LOADV;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_LOADV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          v_nxt     = ram_rdata_a;
          state_nxt = ST_READC;
        end
      end

      ST_READC: begin
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        ram_we = 1'b1;
        case (pick)
          PICK_LEFT: begin
            ram_wdata = ram_rdata_a;
            pos_nxt   = l_idx[IDX_W-1:0];
            state_nxt = ST_READC;
          end
          PICK_RIGHT: begin
            ram_wdata = ram_rdata_b;
            pos_nxt   = r_idx[IDX_W-1:0];
            state_nxt = ST_READC;
          end
          default: begin
            ram_wdata = v_r;
            if (build_r && (bpos_r != '0)) begin
              bpos_nxt  = bpos_r - IDX_W'(1);
              pos_nxt   = bpos_r - IDX_W'(1);
              ram_ra    = bpos_r - IDX_W'(1);
              state_nxt = ST_LOADV;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        endcase
        if (pos_r == '0) begin
          top_nxt = ram_wdata;
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rej_nxt   = rej_r;
          out_cnt_nxt   = cnt_r;
          out_empty_nxt = (cnt_r == '0);
          out_key_nxt   = (cnt_r == '0) ? '0 : port_key_t'(top_r.key);
          out_src_nxt   = (cnt_r == '0) ? '0 : top_r.src;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ordered_r   <= 1'b0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ordered_r   <= ordered_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rej_r       <= rej_nxt;
    pos_r       <= pos_nxt;
    bpos_r      <= bpos_nxt;
    v_r         <= v_nxt;
    top_r       <= top_nxt;
    out_key_r   <= out_key_nxt;
    out_src_r   <= out_src_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_top_key     = out_key_r;
  assign out_top_source  = out_src_r;
  assign out_entry_count = PORT_CNT_W'(out_cnt_r);
  assign out_is_empty    = out_empty_r;
  assign out_rejected    = out_rej_r;

endmodule

`default_nettype wire

/* src/kwm_ram.sv */
// ----------------------------------------------------------------------------
// kwm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                          rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* src/kwm_sift.sv */
// ----------------------------------------------------------------------------
// kwm_sift
// Sift-down decision: chooses between the hole value and its two children.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_sift (
  input  kwm_pkg::key_t      v_key,
  input  kwm_pkg::key_t      l_key,
  input  kwm_pkg::key_t      r_key,
  input  kwm_pkg::child_ok_t ok,
  output kwm_pkg::pick_t     pick
);
  import kwm_pkg::*;

  key_t best_key;

  // A child wins only when strictly smaller, so ties keep the parent and
  // the left child beats an equal right child.
  always_comb begin
    pick     = PICK_PARENT;
    best_key = v_key;
    if (ok.l_ok && (l_key < v_key)) begin
      pick     = PICK_LEFT;
      best_key = l_key;
    end
    if (ok.r_ok && (r_key < best_key)) begin
      pick = PICK_RIGHT;
    end
  end

endmodule

`default_nettype wire

/* src/kwm_chk.sv */
// ----------------------------------------------------------------------------
// kwm_chk
// Port-level checks of the k-way merge min-heap unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_action,
  input logic signed [31:0] in_key,
  input logic [3:0]         in_source,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_top_key,
  input logic [3:0]         out_top_source,
  input logic [4:0]         out_entry_count,
  input logic               out_is_empty,
  input logic               out_rejected
);
  import kwm_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_key)
      && $stable(out_top_source) && $stable(out_entry_count)
      && $stable(out_is_empty) && $stable(out_rejected))
    else $error("result transaction changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_top_key == 32'sd0) && (out_top_source == 4'd0))
    else $error("empty heap reports a nonzero top entry");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= 5'(MAX_LISTS)))
    else $error("entry count beyond capacity");

  // One item in work at a time: an accepted transaction makes the unit busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

endmodule

bind k_way_merge_min_heap_unit kwm_chk u_kwm_chk (.*);

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the k-way merge min-heap unit against a heap predictor kept in step
// with every accepted transaction: loads, builds, replace-top and remove-top
// in merge-shaped sequences with random keys, random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kwm_pkg::*;

  localparam int RANDOM_OPS     = 1450;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    action_t     act;
    logic [31:0] key;
    src_t        src;
  } heap_op_t;

  typedef struct packed {
    port_key_t  top_key;
    src_t       top_source;
    logic [4:0] entry_count;
    logic       is_empty;
    logic       rejected;
  } heap_view_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = ACT_LOAD;
  logic signed [31:0] in_key = '0;
  logic [3:0]         in_source = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_top_key;
  logic [3:0]         out_top_source;
  logic [4:0]         out_entry_count;
  logic               out_is_empty;
  logic               out_rejected;

  k_way_merge_min_heap_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_source       (in_source),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_top_key     (out_top_key),
    .out_top_source  (out_top_source),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_rejected    (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  heap_op_t   pending_ops[$];
  heap_view_t predicted_tops[$];

  int err_count     = 0;
  int ops_in        = 0;
  int tops_out      = 0;
  int refused_seen  = 0;
  int full_seen     = 0;
  int builds_seen   = 0;
  int idle_cycles   = 0;
  int cyc_count     = 0;
  int in_gap        = 0;
  int stall_left    = 0;
  logic in_took     = 1'b0;

  // Shadow of the entry count while the op list is planned.
  int plan_size  = 0;
  bit plan_built = 1'b0;
  int queued_total = 0;

  // Predicted heap contents.
  key_t        heap_key [MAX_LISTS];
  src_t        heap_src [MAX_LISTS];
  int unsigned heap_size = 0;
  bit          heap_heapified = 1'b0;

  // Both channels run without gaps for part of every stretch.
  wire calm = (cyc_count % 700) < 200;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2: return 32'($urandom_range(0, 4)) - 32'd2;
      default: return $urandom;
    endcase
  endfunction

  function automatic src_t rand_src();
    return src_t'($urandom_range(0, 15));
  endfunction

  // A child takes the parent's place only when strictly smaller; the right
  // child must also beat the left one, so ties keep the parent or go left.
  function automatic void sink_entry(int unsigned p, int unsigned n);
    int unsigned l;
    int unsigned r;
    int unsigned m;
    key_t        tk;
    src_t        ts;
    while (p < n) begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      m = p;
      if (l < n && heap_key[l] < heap_key[m]) m = l;
      if (r < n && heap_key[r] < heap_key[m]) m = r;
      if (m == p) break;
      tk = heap_key[p];
      ts = heap_src[p];
      heap_key[p] = heap_key[m];
      heap_src[p] = heap_src[m];
      heap_key[m] = tk;
      heap_src[m] = ts;
      p = m;
    end
  endfunction

  function automatic heap_view_t merge_heap_update(action_t act, key_t k, src_t s);
    heap_view_t res;
    int         i;
    res.rejected = 1'b0;
    case (act)
      ACT_LOAD: begin
        if (heap_size >= MAX_LISTS || heap_heapified) begin
          res.rejected = 1'b1;
        end else begin
          heap_key[heap_size] = k;
          heap_src[heap_size] = s;
          heap_size++;
        end
      end
      ACT_BUILD: begin
        if (heap_size > 0) begin
          for (i = int'((heap_size - 1) / 2); i >= 0; i--) sink_entry(i, heap_size);
        end
        heap_heapified = 1'b1;
      end
      ACT_REPLACE: begin
        if (heap_size == 0) begin
          res.rejected = 1'b1;
        end else begin
          heap_key[0] = k;
          sink_entry(0, heap_size);
        end
      end
      default: begin
        if (heap_size == 0) begin
          res.rejected = 1'b1;
        end else begin
          heap_size--;
          heap_key[0] = heap_key[heap_size];
          heap_src[0] = heap_src[heap_size];
          sink_entry(0, heap_size);
          if (heap_size == 0) heap_heapified = 1'b0;
        end
      end
    endcase
    if (heap_size > 0) begin
      res.top_key    = port_key_t'(heap_key[0]);
      res.top_source = heap_src[0];
      res.is_empty   = 1'b0;
    end else begin
      res.top_key    = '0;
      res.top_source = '0;
      res.is_empty   = 1'b1;
    end
    res.entry_count = 5'(heap_size);
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("tb_top: mismatch at result %0d: %s", tops_out, msg);
    err_count++;
  endtask

  task automatic queue_op(action_t a, logic [31:0] k, src_t s);
    heap_op_t op;
    op.act = a;
    op.key = k;
    op.src = s;
    pending_ops.push_back(op);
    queued_total++;
    case (a)
      ACT_LOAD: if (plan_size < MAX_LISTS && !plan_built) plan_size++;
      ACT_BUILD: plan_built = 1'b1;
      ACT_REMOVE: begin
        if (plan_size > 0) begin
          plan_size--;
          if (plan_size == 0) plan_built = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(negedge clk) begin : drive
    heap_op_t next_op;
    cyc_count <= cyc_count + 1;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          next_op   = pending_ops.pop_front();
          in_valid  <= 1'b1;
          in_action <= next_op.act;
          in_key    <= next_op.key;
          in_source <= next_op.src;
          in_gap    <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watch
    heap_view_t want;
    logic       moved;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        want = merge_heap_update(action_t'(in_action), in_key, in_source);
        predicted_tops.push_back(want);
        ops_in++;
        if (want.rejected) refused_seen++;
        if (want.entry_count == 5'd16) full_seen++;
        if (action_t'(in_action) == ACT_BUILD) builds_seen++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (predicted_tops.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          want = predicted_tops.pop_front();
          if (out_top_key !== want.top_key)
            flag_mismatch($sformatf("top_key got %0d want %0d",
                                    out_top_key, $signed(want.top_key)));
          if (out_top_source !== want.top_source)
            flag_mismatch($sformatf("top_source got %0d want %0d",
                                    out_top_source, want.top_source));
          if (out_entry_count !== want.entry_count)
            flag_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_entry_count, want.entry_count));
          if (out_is_empty !== want.is_empty)
            flag_mismatch($sformatf("is_empty got %b want %b",
                                    out_is_empty, want.is_empty));
          if (out_rejected !== want.rejected)
            flag_mismatch($sformatf("rejected got %b want %b",
                                    out_rejected, want.rejected));
        end
        tops_out++;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int      directed_total;
    int      fill;
    int      r;
    action_t a;

    // Empty heap: both pops are refused.
    queue_op(ACT_REPLACE, 32'h0000_0001, 4'd0);
    queue_op(ACT_REMOVE,  32'h0000_0000, 4'd0);
    // Key and source extremes, then pops on the unordered array.
    queue_op(ACT_LOAD, 32'h7fff_ffff, 4'd15);
    queue_op(ACT_LOAD, 32'h8000_0000, 4'd0);
    queue_op(ACT_LOAD, 32'h0000_0000, 4'd5);
    queue_op(ACT_LOAD, 32'hffff_ffff, 4'd10);
    queue_op(ACT_REPLACE, 32'h0000_0005, 4'd3);
    queue_op(ACT_REMOVE,  32'h0000_0000, 4'd0);
    // Fill to the top with many equal keys so that ties decide the order.
    while (plan_size < MAX_LISTS)
      queue_op(ACT_LOAD, 32'($urandom_range(0, 2)) - 32'd1, rand_src());
    queue_op(ACT_LOAD, 32'h0000_0042, 4'd7);
    queue_op(ACT_BUILD, 32'h0, 4'd0);
    queue_op(ACT_LOAD, 32'h0000_0001, 4'd1);
    queue_op(ACT_BUILD, 32'h0, 4'd0);
    directed_total = queued_total;

    while (queued_total < directed_total + RANDOM_OPS) begin
      if ($urandom_range(0, 19) == 0) begin
        a = action_t'($urandom_range(0, 3));
        // A build on an empty heap locks out loads for good; it comes last.
        if (a == ACT_BUILD && plan_size == 0) a = ACT_LOAD;
        queue_op(a, rand_key(), rand_src());
      end else if (!plan_built) begin
        fill = $urandom_range(1, MAX_LISTS);
        while (plan_size < fill) queue_op(ACT_LOAD, rand_key(), rand_src());
        if (plan_size == MAX_LISTS && $urandom_range(0, 2) == 0)
          queue_op(ACT_LOAD, rand_key(), rand_src());
        queue_op(ACT_BUILD, rand_key(), rand_src());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)      queue_op(ACT_REPLACE, rand_key(), rand_src());
        else if (r < 88) queue_op(ACT_REMOVE, rand_key(), rand_src());
        else if (r < 94) queue_op(ACT_BUILD, rand_key(), rand_src());
        else             queue_op(ACT_LOAD, rand_key(), rand_src());
      end
    end

    while (plan_size > 0) queue_op(ACT_REMOVE, rand_key(), rand_src());
    queue_op(ACT_BUILD, 32'h0, 4'd0);
    queue_op(ACT_LOAD, 32'h0000_0003, 4'd2);
    queue_op(ACT_REPLACE, 32'h0000_0004, 4'd0);
    queue_op(ACT_REMOVE, 32'h0, 4'd0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || predicted_tops.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_tops.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", predicted_tops.size()));

    $display("tb_top: %0d transactions in, %0d results checked, %0d refused",
             ops_in, tops_out, refused_seen);
    $display("tb_top: %0d builds, %0d results with a full heap", builds_seen, full_seen);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
